// ----- hw/rtl/lad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lad_pkg: shared types and codes of the linear array deque
// Command and status codes, the input and result transfer types, and the
// status group passed from the control unit to the top level.
// ----------------------------------------------------------------------------
package lad_pkg;

	localparam int CMD_W   = 2;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 7;
	localparam int CAP_W   = 7;
	localparam int CAP_RST = 64;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	// register word index (paddr[2])
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_REAR  = 2'd1,
		CMD_DEL_FRONT = 2'd2,
		CMD_DEL_REAR  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         count;
		logic                     is_empty;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
	} result_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
	} info_t;

endpackage : lad_pkg
`default_nettype wire

// ----- hw/rtl/lad_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lad_regs: configuration register file
// APB-style slave holding the capacity register; always ready.
// ----------------------------------------------------------------------------
module lad_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lad_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lad_pkg::APB_W-1:0]   pwdata,
	output logic      [lad_pkg::APB_W-1:0]   prdata,
	output logic                             pready,
	output logic      [lad_pkg::CAP_W-1:0]   capacity
);
	import lad_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             wr_capacity;

	// decode the access phase of a write transfer
	assign wr_capacity = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	// hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(CAP_RST);
		end else if (wr_capacity) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_CAPACITY: prdata = APB_W'(capacity_q);
			default:      prdata = '0;
		endcase
	end

	assign pready   = 1'b1;
	assign capacity = capacity_q;

endmodule : lad_regs
`default_nettype wire

// ----- hw/rtl/lad_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lad_mem: slot memory
// One write port and two registered read ports; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module lad_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [lad_pkg::DATA_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr_f,
	input  wire logic [AW-1:0]             raddr_r,
	output logic      [lad_pkg::DATA_W-1:0] rdata_f,
	output logic      [lad_pkg::DATA_W-1:0] rdata_r
);
	import lad_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_f_q;
	logic [DATA_W-1:0] rdata_r_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, forward the write data on an address match
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_f_q <= (we && (waddr == raddr_f)) ? wdata : mem[raddr_f];
			rdata_r_q <= (we && (waddr == raddr_r)) ? wdata : mem[raddr_r];
		end
	end

	assign rdata_f = rdata_f_q;
	assign rdata_r = rdata_r_q;

endmodule : lad_mem
`default_nettype wire

// ----- hw/rtl/lad_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lad_ctrl: index control
// Holds the front and rear indices, decodes each command, drives the slot
// write and the reads of the new ends, and registers the status group.
// The rear is kept as rear index plus one so that both indices are unsigned.
// ----------------------------------------------------------------------------
module lad_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int IW    = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire lad_pkg::item_t             item,
	input  wire logic [lad_pkg::CAP_W-1:0]  capacity,
	output logic                            we,
	output logic      [AW-1:0]              waddr,
	output logic      [lad_pkg::DATA_W-1:0] wdata,
	output logic      [AW-1:0]              raddr_f,
	output logic      [AW-1:0]              raddr_r,
	output logic                            valid_s1,
	output lad_pkg::info_t                  info_s1
);
	import lad_pkg::*;

	localparam int CW = (IW > CAP_W) ? IW : CAP_W;

	logic [IW-1:0] front_q, rearp_q;
	logic          started_q;
	logic [IW-1:0] front_n, rearp_n;
	logic          started_n;
	logic [IW-1:0] front_m1, rear_n;
	logic [CW-1:0] cap_ext, cap_used;
	logic          empty_now, empty_n, wr_req;
	status_t       status_n;
	info_t         info_n;

	// clamp capacity to 1..DEPTH
	always_comb begin
		cap_ext  = CW'(capacity);
		cap_used = cap_ext;
		if (cap_ext == '0) begin
			cap_used = CW'(1);
		end else if (cap_ext > CW'(DEPTH)) begin
			cap_used = CW'(DEPTH);
		end
	end

	assign empty_now = !started_q || (front_q >= rearp_q);
	assign front_m1  = front_q - IW'(1);

	// decode the command and compute the next indices
	always_comb begin
		front_n   = front_q;
		rearp_n   = rearp_q;
		started_n = started_q;
		wr_req    = 1'b0;
		waddr     = '0;
		status_n  = ST_DONE;
		unique case (cmd_t'(item.command))
			CMD_INS_FRONT: begin
				if (!started_q) begin
					front_n   = '0;
					rearp_n   = IW'(1);
					started_n = 1'b1;
					wr_req    = 1'b1;
				end else if (front_q == '0) begin
					status_n = ST_FULL;
				end else begin
					front_n = front_m1;
					wr_req  = 1'b1;
					waddr   = front_m1[AW-1:0];
				end
			end
			CMD_INS_REAR: begin
				if (CW'(rearp_q) >= cap_used) begin
					status_n = ST_FULL;
				end else begin
					rearp_n   = rearp_q + IW'(1);
					started_n = 1'b1;
					wr_req    = 1'b1;
					waddr     = rearp_q[AW-1:0];
				end
			end
			CMD_DEL_FRONT: begin
				if (empty_now) begin
					status_n = ST_EMPTY;
				end else begin
					front_n = front_q + IW'(1);
				end
			end
			CMD_DEL_REAR: begin
				if (empty_now) begin
					status_n = ST_EMPTY;
				end else begin
					rearp_n = rearp_q - IW'(1);
				end
			end
			default: status_n = ST_DONE;
		endcase
	end

	// result of the command
	always_comb begin
		empty_n         = !started_n || (front_n >= rearp_n);
		rear_n          = rearp_n - IW'(1);
		info_n.status   = status_n;
		info_n.is_empty = empty_n;
		info_n.count    = empty_n ? '0 : CNT_W'(rearp_n - front_n);
	end

	assign we      = accept && wr_req;
	assign wdata   = item.value;
	assign raddr_f = front_n[AW-1:0];
	assign raddr_r = rear_n[AW-1:0];

	// advance the indices on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			rearp_q   <= '0;
			started_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				front_q   <= front_n;
				rearp_q   <= rearp_n;
				started_q <= started_n;
			end
		end
	end

	// register the status group alongside the read data
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info_n;
		end
	end

	// front never passes the rear by more than one slot
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= rearp_q)
		else $error("front index beyond rear");

	// a refused command leaves the indices alone
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (info_n.status != ST_DONE)) |=>
			($stable(front_q) && $stable(rearp_q) && $stable(started_q)))
		else $error("refused command moved an index");

	// the queue never returns to the fresh state
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("started flag cleared");

endmodule : lad_ctrl
`default_nettype wire

// ----- hw/rtl/linear_array_deque_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linear_array_deque_core: double-ended queue on a linear array
// Insert or delete at either end of a non-circular slot array, one result
// per command.
// ----------------------------------------------------------------------------
// Takes one command per clock cycle: busy stays low, and the result of a
// command accepted with start appears on result, marked by done, in the
// next cycle, for one cycle only; the receiver must take it then. The
// read data is registered by the slot memory, which takes the slot write
// and reads the new front and rear slots in the accept cycle.
// Space freed at one end is not reused by the other end; capacity (APB byte
// address 0) limits the rear, with 0 acting as 1 and values above DEPTH as
// DEPTH. Front and rear values read as zero while the queue is empty.
module linear_array_deque_core #(
	parameter int DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire lad_pkg::item_t              item,
	output logic                             done,
	output lad_pkg::result_t                 result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lad_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lad_pkg::APB_W-1:0]   pwdata,
	output logic      [lad_pkg::APB_W-1:0]   prdata,
	output logic                             pready
);
	import lad_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]  capacity;
	logic              accept;
	logic              we;
	logic [AW-1:0]     waddr, raddr_f, raddr_r;
	logic [DATA_W-1:0] wdata, rdata_f, rdata_r;
	logic              valid_s1;
	info_t             info_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	lad_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	lad_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.IW    (IW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.capacity (capacity),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr_f  (raddr_f),
		.raddr_r  (raddr_r),
		.valid_s1 (valid_s1),
		.info_s1  (info_s1)
	);

	lad_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (accept),
		.raddr_f (raddr_f),
		.raddr_r (raddr_r),
		.rdata_f (rdata_f),
		.rdata_r (rdata_r)
	);

	// assemble the result transfer, zero the ends while empty
	always_comb begin
		result.status      = info_s1.status;
		result.count       = info_s1.count;
		result.is_empty    = info_s1.is_empty;
		result.front_value = info_s1.is_empty ? '0 : rdata_f;
		result.rear_value  = info_s1.is_empty ? '0 : rdata_r;
	end

	assign done = valid_s1;

	// every accepted command yields a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done)
		else $error("result missing after accepted command");

	// empty flag agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.count == '0)))
		else $error("empty flag and count disagree");

endmodule : linear_array_deque_core
`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: regression bench for the linear array deque core
// Drives insert and delete commands at both ends of the deque and checks
// every result against a predictor that tracks the front and rear indexes
// and the slot contents. Directed cases come first: deletes on a fresh
// queue, the first insertion, refusals at the front and the rear, and
// capacity limits. Random phases with varied command mixes and capacity
// settings follow.
// ----------------------------------------------------------------------------
module tb_top;
	import lad_pkg::*;

	localparam int DEPTH          = 64;
	localparam int PHASE_ITEMS    = 250;
	localparam int PHASE_COUNT    = 7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [PADDR_W-1:0] CAP_ADDR   = 3'd0;
	localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	item_t              item;
	logic               done;
	result_t            result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0]   pwdata;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	// predictor state
	logic [DATA_W-1:0] slot_mem [DEPTH];
	int                front_idx;
	int                rear_idx;
	bit                started;
	logic [CAP_W-1:0]  cap_value;

	result_t due_results [$];
	int      fail_count;
	int      idle_cycles;

	linear_array_deque_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit deque_empty();
		return !started || front_idx > rear_idx;
	endfunction

	// Apply one command to the predictor and return the result it implies
	function automatic result_t deque_apply(item_t it);
		result_t          r;
		logic [CAP_W-1:0] c;
		int               lim;
		bit               empty;
		r = '0;
		r.status = ST_DONE;
		c = cap_value;
		if (c < 1)
			c = CAP_W'(1);
		if (c > DEPTH)
			c = CAP_W'(DEPTH);
		lim = int'(c);
		case (cmd_t'(it.command))
			CMD_INS_FRONT: begin
				if (!started) begin
					front_idx = 0;
					rear_idx = 0;
					started = 1'b1;
					slot_mem[0] = it.value;
				end else if (front_idx <= 0) begin
					r.status = ST_FULL;
				end else begin
					front_idx--;
					slot_mem[front_idx] = it.value;
				end
			end
			CMD_INS_REAR: begin
				if (rear_idx >= lim - 1) begin
					r.status = ST_FULL;
				end else begin
					rear_idx++;
					slot_mem[rear_idx] = it.value;
					if (!started) begin
						front_idx = 0;
						started = 1'b1;
					end
				end
			end
			CMD_DEL_FRONT: begin
				if (deque_empty())
					r.status = ST_EMPTY;
				else
					front_idx++;
			end
			default: begin
				if (deque_empty())
					r.status = ST_EMPTY;
				else
					rear_idx--;
			end
		endcase
		empty = deque_empty();
		r.is_empty = empty;
		r.count = empty ? '0 : CNT_W'(rear_idx - front_idx + 1);
		r.front_value = empty ? '0 : slot_mem[front_idx];
		r.rear_value = empty ? '0 : slot_mem[rear_idx];
		return r;
	endfunction

	function automatic item_t make_item(cmd_t cmd, logic [DATA_W-1:0] val);
		item_t it;
		it.command = cmd;
		it.value = val;
		return it;
	endfunction

	// Pick an element, with the sign and all-ones extremes now and then
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Send one command; entered at a falling edge, returns at a falling edge
	// with start still high so a burst can go on without a gap
	task automatic send_item(item_t it);
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		due_results.push_back(deque_apply(it));
		@(negedge clk);
	endtask

	// Drop start and hold off for the given number of cycles
	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Drop start and wait until every expected result has come
	task automatic drain();
		start <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [APB_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (addr[2] == REG_CAPACITY)
			cap_value = data[CAP_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [APB_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Write capacity with random upper bits, then read it back
	task automatic set_capacity(logic [CAP_W-1:0] cap);
		logic [APB_W-1:0] rd;
		apb_write(CAP_ADDR, {25'($urandom_range(0, 33554431)), cap});
		apb_read(CAP_ADDR, rd);
		if (rd !== {{(APB_W-CAP_W){1'b0}}, cap}) begin
			$error("capacity readback: expected %0d, got %0d", cap, rd);
			fail_count++;
		end
	endtask

	// Deletes before anything was ever inserted
	task automatic test_fresh_empty();
		send_item(make_item(CMD_DEL_FRONT, $urandom));
		send_item(make_item(CMD_DEL_REAR, $urandom));
		drain();
	endtask

	// First insertion, front refusal at slot 0, growth at the rear,
	// emptying from the rear, and a front refusal while empty
	task automatic test_end_limits();
		if ($urandom_range(0, 1))
			send_item(make_item(CMD_INS_FRONT, 32'h7FFF_FFFF));
		else
			send_item(make_item(CMD_INS_REAR, 32'h7FFF_FFFF));
		send_item(make_item(CMD_INS_FRONT, 32'h1234_5678));
		send_item(make_item(CMD_INS_REAR, 32'h8000_0000));
		send_item(make_item(CMD_INS_REAR, 32'h0000_0000));
		pause(3);
		send_item(make_item(CMD_INS_REAR, 32'hFFFF_FFFF));
		send_item(make_item(CMD_DEL_FRONT, $urandom));
		send_item(make_item(CMD_INS_FRONT, 32'h5555_5555));
		repeat (4) send_item(make_item(CMD_DEL_REAR, $urandom));
		send_item(make_item(CMD_INS_FRONT, 32'hAAAA_AAAA));
		send_item(make_item(CMD_DEL_FRONT, $urandom));
		send_item(make_item(CMD_INS_REAR, 32'hAAAA_AAAA));
		drain();
	endtask

	// Capacity extremes: one slot, zero, above depth, and rear already
	// beyond a lowered limit
	task automatic test_capacity();
		set_capacity(7'd1);
		send_item(make_item(CMD_INS_REAR, $urandom));
		drain();
		set_capacity(7'd0);
		send_item(make_item(CMD_INS_REAR, $urandom));
		drain();
		set_capacity(7'd127);
		repeat (3) send_item(make_item(CMD_INS_REAR, $urandom));
		drain();
		set_capacity(7'd2);
		send_item(make_item(CMD_INS_REAR, $urandom));
		send_item(make_item(CMD_DEL_REAR, $urandom));
		drain();
		apb_write(SPARE_ADDR, $urandom);
		set_capacity(7'd65);
		send_item(make_item(CMD_INS_REAR, $urandom));
		drain();
		set_capacity(7'd64);
	endtask

	// Random phases: each with its own capacity and command mix, sent in
	// bursts with random gaps
	task automatic test_random_mix();
		int   weight [4];
		int   total;
		int   pick;
		int   sent;
		int   burst;
		cmd_t cmd;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain();
			case (ph)
				0: set_capacity(7'd64);
				1: set_capacity(7'd1);
				2: set_capacity(7'd0);
				3: set_capacity(7'd127);
				default: set_capacity(CAP_W'($urandom_range(1, 127)));
			endcase
			if ($urandom_range(0, 2) == 0)
				apb_write(SPARE_ADDR, $urandom);
			total = 0;
			for (int k = 0; k < 4; k++) begin
				weight[k] = $urandom_range(1, 10);
				total += weight[k];
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					burst = $urandom_range(30, 80);
				else
					burst = $urandom_range(1, 12);
				repeat (burst) begin
					pick = $urandom_range(0, total - 1);
					if (pick < weight[0])
						cmd = CMD_INS_FRONT;
					else if (pick < weight[0] + weight[1])
						cmd = CMD_INS_REAR;
					else if (pick < weight[0] + weight[1] + weight[2])
						cmd = CMD_DEL_FRONT;
					else
						cmd = CMD_DEL_REAR;
					send_item(make_item(cmd, pick_value()));
					sent++;
				end
				pause($urandom_range(1, 6));
			end
		end
		drain();
	endtask

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (due_results.size() == 0) begin
				$error("result transfer with no expectation pending");
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, result.count);
					fail_count++;
				end
				if (result.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty,
						result.is_empty);
					fail_count++;
				end
				if (result.front_value !== want.front_value) begin
					$error("front_value: expected %0d, got %0d", want.front_value,
						result.front_value);
					fail_count++;
				end
				if (result.rear_value !== want.rear_value) begin
					$error("rear_value: expected %0d, got %0d", want.rear_value,
						result.rear_value);
					fail_count++;
				end
			end
		end
	end

	// Count cycles without any transfer and stop the run when stuck
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no transfer for %0d cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		idle_cycles = 0;
		front_idx = -1;
		rear_idx = -1;
		started = 1'b0;
		cap_value = CAP_W'(CAP_RST);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_fresh_empty();
		test_end_limits();
		test_capacity();
		test_random_mix();

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/lad_pkg.sv
hw/rtl/lad_regs.sv
hw/rtl/lad_mem.sv
hw/rtl/lad_ctrl.sv
hw/rtl/linear_array_deque_core.sv
verif/tb_top.sv
